### rtl/lqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear queue with cancel: shared definitions
// Request and result formats, status codes and the microcode store that
// sequences the queue datapath.
// ----------------------------------------------------------------------------
package lqc_pkg;

    localparam int DEPTH     = 8;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int UPC_W     = 5;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [UPC_W-1:0]     upc_t;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_DUMP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] ticket_key;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_key;
        logic        last;
    } result_t;

    // Datapath actions of one microcode step.
    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_PUSH_FIRST,
        ACT_PUSH_TAIL,
        ACT_POP,
        ACT_SET_I,
        ACT_INC_I,
        ACT_SHIFT,
        ACT_CANCEL_FIN
    } act_t;

    // Jump conditions; a false condition falls through or finishes.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_EMPTY,
        C_TAIL_LAST,
        C_MATCH,
        C_AT_TAIL,
        C_NOT_AT_TAIL
    } cond_t;

    typedef struct packed {
        act_t    act;
        cond_t   cond;
        upc_t    target;
        logic    fin;
        logic    emit;
        status_t status;
        logic    key_from_store;
        logic    last_at_tail;
        logic    rd_next;
    } uword_t;

    // Entry points of the four routines.
    localparam upc_t UA_PUSH   = 5'd0;
    localparam upc_t UA_POP    = 5'd5;
    localparam upc_t UA_CANCEL = 5'd7;
    localparam upc_t UA_DUMP   = 5'd15;

    // Shared tails and loop heads.
    localparam upc_t UA_PUSH_FIRST = 5'd3;
    localparam upc_t UA_PUSH_FULL  = 5'd4;
    localparam upc_t UA_SEARCH     = 5'd9;
    localparam upc_t UA_SHIFT      = 5'd12;
    localparam upc_t UA_CANCEL_FIN = 5'd14;
    localparam upc_t UA_DUMP_LOOP  = 5'd17;
    localparam upc_t UA_NOT_FOUND  = 5'd18;
    localparam upc_t UA_EMPTY      = 5'd19;

    function automatic uword_t uw(
        input act_t    act,
        input cond_t   cond,
        input upc_t    target,
        input logic    fin,
        input logic    emit,
        input status_t status,
        input logic    key_from_store,
        input logic    last_at_tail,
        input logic    rd_next
    );
        uword_t w;
        w.act            = act;
        w.cond           = cond;
        w.target         = target;
        w.fin            = fin;
        w.emit           = emit;
        w.status         = status;
        w.key_from_store = key_from_store;
        w.last_at_tail   = last_at_tail;
        w.rd_next        = rd_next;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input upc_t pc);
        uword_t w;
        unique case (pc)
            // push
            5'd0:  w = uw(ACT_NOP, C_EMPTY, UA_PUSH_FIRST, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd1:  w = uw(ACT_NOP, C_TAIL_LAST, UA_PUSH_FULL, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0,
                          1'b0);
            5'd2:  w = uw(ACT_PUSH_TAIL, C_NEVER, UA_PUSH, 1'b1, 1'b1, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd3:  w = uw(ACT_PUSH_FIRST, C_NEVER, UA_PUSH, 1'b1, 1'b1, ST_OK, 1'b0, 1'b0,
                          1'b0);
            5'd4:  w = uw(ACT_NOP, C_NEVER, UA_PUSH, 1'b1, 1'b1, ST_FULL, 1'b0, 1'b0, 1'b0);
            // pop
            5'd5:  w = uw(ACT_SET_I, C_EMPTY, UA_EMPTY, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd6:  w = uw(ACT_POP, C_NEVER, UA_PUSH, 1'b1, 1'b1, ST_OK, 1'b1, 1'b0, 1'b0);
            // cancel
            5'd7:  w = uw(ACT_NOP, C_EMPTY, UA_EMPTY, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd8:  w = uw(ACT_SET_I, C_NEVER, UA_PUSH, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd9:  w = uw(ACT_NOP, C_MATCH, UA_SHIFT, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd10: w = uw(ACT_NOP, C_AT_TAIL, UA_NOT_FOUND, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0,
                          1'b0);
            5'd11: w = uw(ACT_INC_I, C_ALWAYS, UA_SEARCH, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd12: w = uw(ACT_NOP, C_AT_TAIL, UA_CANCEL_FIN, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0,
                          1'b0);
            5'd13: w = uw(ACT_SHIFT, C_ALWAYS, UA_SHIFT, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b1);
            5'd14: w = uw(ACT_CANCEL_FIN, C_NEVER, UA_PUSH, 1'b1, 1'b1, ST_OK, 1'b0, 1'b0,
                          1'b0);
            // dump
            5'd15: w = uw(ACT_NOP, C_EMPTY, UA_EMPTY, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd16: w = uw(ACT_SET_I, C_NEVER, UA_PUSH, 1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            5'd17: w = uw(ACT_INC_I, C_NOT_AT_TAIL, UA_DUMP_LOOP, 1'b1, 1'b1, ST_OK, 1'b1,
                          1'b1, 1'b0);
            // shared endings
            5'd18: w = uw(ACT_NOP, C_NEVER, UA_PUSH, 1'b1, 1'b1, ST_NOT_FOUND, 1'b0, 1'b0,
                          1'b0);
            5'd19: w = uw(ACT_NOP, C_NEVER, UA_PUSH, 1'b1, 1'b1, ST_EMPTY, 1'b0, 1'b0, 1'b0);
            default: w = uw(ACT_NOP, C_NEVER, UA_PUSH, 1'b1, 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

### rtl/linear_queue_with_cancel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear queue with cancel
// Eight-slot linear queue of ticket keys with push, pop, cancel by key and
// dump, sequenced by a small microcode store over a one-read-port datapath.
// ----------------------------------------------------------------------------
// Busy stays high until the final result is registered, so one request is in
// work at a time; the microcode step counter and the single store read port
// set the pace. Dump strobes one result per cycle; the receiver cannot stall.
// Reset clears the indices and marks the queue empty; key slots are not cleared.
module linear_queue_with_cancel_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lqc_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           result_valid,
    output lqc_pkg::result_t result
);
    import lqc_pkg::*;

    key_t    key_store_reg [DEPTH];

    logic    run_reg,   run_next;
    upc_t    pc_reg,    pc_next;
    idx_t    head_reg,  head_next;
    idx_t    tail_reg,  tail_next;
    idx_t    i_reg,     i_next;
    logic    empty_reg, empty_next;
    key_t    key_reg,   key_next;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg,       result_next;

    uword_t  uword;
    idx_t    rd_addr;
    key_t    rd_data;
    logic    at_tail;
    logic    cond_true;
    logic    wr_en;
    idx_t    wr_addr;
    key_t    wr_data;

    always_comb
    begin
        uword   = ucode_rom(pc_reg);
        rd_addr = uword.rd_next ? idx_t'(i_reg + 1'b1) : i_reg;
        rd_data = key_store_reg[rd_addr];
        at_tail = (i_reg == tail_reg);

        case (uword.cond)
            C_ALWAYS:      cond_true = 1'b1;
            C_EMPTY:       cond_true = empty_reg;
            C_TAIL_LAST:   cond_true = (tail_reg == idx_t'(DEPTH - 1));
            C_MATCH:       cond_true = (rd_data == key_reg);
            C_AT_TAIL:     cond_true = at_tail;
            C_NOT_AT_TAIL: cond_true = !at_tail;
            default:       cond_true = 1'b0;
        endcase

        run_next          = run_reg;
        pc_next           = pc_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        i_next            = i_reg;
        empty_next        = empty_reg;
        key_next          = key_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_addr           = i_reg;
        wr_data           = key_reg;

        if (!run_reg)
        begin
            if (start)
            begin
                run_next = 1'b1;
                key_next = key_t'(cmd.ticket_key);
                unique case (cmd.opcode)
                    OP_PUSH:   pc_next = UA_PUSH;
                    OP_POP:    pc_next = UA_POP;
                    OP_CANCEL: pc_next = UA_CANCEL;
                    OP_DUMP:   pc_next = UA_DUMP;
                    default:   pc_next = UA_PUSH;
                endcase
            end
        end
        else
        begin
            case (uword.act)
                ACT_PUSH_FIRST:
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                end
                ACT_PUSH_TAIL:
                begin
                    wr_en     = 1'b1;
                    wr_addr   = idx_t'(tail_reg + 1'b1);
                    tail_next = idx_t'(tail_reg + 1'b1);
                end
                ACT_POP:
                begin
                    if (head_reg >= tail_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        head_next = idx_t'(head_reg + 1'b1);
                    end
                end
                ACT_SET_I:
                begin
                    i_next = head_reg;
                end
                ACT_INC_I:
                begin
                    i_next = idx_t'(i_reg + 1'b1);
                end
                ACT_SHIFT:
                begin
                    wr_en   = 1'b1;
                    wr_addr = i_reg;
                    wr_data = rd_data;
                    i_next  = idx_t'(i_reg + 1'b1);
                end
                ACT_CANCEL_FIN:
                begin
                    if (tail_reg <= head_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        tail_next = idx_t'(tail_reg - 1'b1);
                    end
                end
                default:
                begin
                end
            endcase

            if (uword.emit)
            begin
                result_valid_next   = 1'b1;
                result_next.status  = uword.status;
                result_next.out_key = uword.key_from_store ? 32'(rd_data) : 32'd0;
                result_next.last    = uword.last_at_tail ? at_tail : 1'b1;
            end

            // A taken jump wins; otherwise the word either ends the request or falls through.
            if (cond_true)
            begin
                pc_next = uword.target;
            end
            else if (uword.fin)
            begin
                run_next = 1'b0;
            end
            else
            begin
                pc_next = upc_t'(pc_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg          <= 1'b0;
            pc_reg           <= UA_PUSH;
            head_reg         <= '0;
            tail_reg         <= '0;
            i_reg            <= '0;
            empty_reg        <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg          <= run_next;
            pc_reg           <= pc_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            i_reg            <= i_next;
            empty_reg        <= empty_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        result_reg <= result_next;
        if (wr_en)
        begin
            key_store_reg[wr_addr] <= wr_data;
        end
    end

    assign busy         = run_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobed with no request in work");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_empty_indices: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty queue with indices away from slot zero");

    a_head_not_past_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (head_reg <= tail_reg))
        else $error("head index passed tail index");
`endif

endmodule
